FILE: design/erm_pkg.sv
// Shared types and constants for the echo ranging median filter.
`default_nettype none

package erm_pkg;

	localparam int PULSE_W   = 16;
	localparam int DIST_W    = 17;
	localparam int SAMPLES_W = 3;
	localparam int REG_IDX_W = 2;

	// Distance in Q8 centimetres is (pulse_us * 4496) >> 10.
	localparam int MUL_W      = 13;
	localparam int DIST_SHIFT = 10;
	localparam logic [MUL_W-1:0] DIST_MUL = 13'd4496;
	localparam int PROD_W     = PULSE_W + MUL_W;
	localparam int FULL_DIST_W = PROD_W - DIST_SHIFT;

	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_DIST  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DIST  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

	localparam logic [PULSE_W-1:0] TIMEOUT_RESET   = 16'd30000;
	localparam logic [DIST_W-1:0]  MIN_DIST_RESET  = 17'd512;
	localparam logic [DIST_W-1:0]  MAX_DIST_RESET  = 17'd102400;
	localparam logic [DIST_W-1:0]  THRESHOLD_RESET = 17'd0;

	// One classified echo as handed from the front end to the window logic.
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] distance;
	} sample_t;

endpackage

`default_nettype wire

FILE: design/erm_front.sv
// Front end: accepts echo requests, converts pulse width to distance and checks limits.
`default_nettype none

module erm_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         echo_rose,
	input  wire logic [erm_pkg::PULSE_W-1:0]  pulse_us,
	input  wire logic [erm_pkg::PULSE_W-1:0]  timeout_us,
	input  wire logic [erm_pkg::DIST_W-1:0]   min_distance_q8,
	input  wire logic [erm_pkg::DIST_W-1:0]   max_distance_q8,
	output logic                              q_push,
	output erm_pkg::sample_t                  q_data,
	input  wire logic                         q_full
);
	import erm_pkg::*;

	logic                   valid_s1;
	logic                   ok_s1;
	logic [PULSE_W-1:0]     pulse_s1;
	logic                   valid_s2;
	logic                   ok_s2;
	logic [FULL_DIST_W-1:0] dist_s2;

	logic                   accept;
	logic                   adv_s1;
	logic                   adv_s2;
	logic [PROD_W-1:0]      product;

	assign full    = valid_s1;
	assign accept  = push && !valid_s1;
	assign adv_s2  = valid_s2 && !q_full;
	assign adv_s1  = valid_s1 && (!valid_s2 || adv_s2);
	assign product = PROD_W'(pulse_s1) * PROD_W'(DIST_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pulse_s1 <= pulse_us;
			ok_s1    <= echo_rose && (pulse_us < timeout_us);
		end
		if (adv_s1) begin
			dist_s2 <= product[PROD_W-1:DIST_SHIFT];
			ok_s2   <= ok_s1;
		end
	end

	// The limits are checked at full width, so a distance beyond 17 bits always fails.
	assign q_push          = adv_s2;
	assign q_data.valid    = ok_s2 && (dist_s2 != '0)
		&& (dist_s2 >= FULL_DIST_W'(min_distance_q8))
		&& (dist_s2 <= FULL_DIST_W'(max_distance_q8));
	assign q_data.distance = dist_s2[DIST_W-1:0];

endmodule

`default_nettype wire

FILE: design/erm_queue.sv
// Two-entry queue of classified samples between the front end and the window logic.
`default_nettype none

module erm_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  erm_pkg::sample_t      push_data,
	output logic                  full,
	input  wire logic             pop,
	output erm_pkg::sample_t      pop_data,
	output logic                  empty
);
	import erm_pkg::*;

	sample_t     entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: design/erm_back.sv
// Back end: ring window update, rank-based median search and the result register.
`default_nettype none

module erm_back #(
	parameter int WINDOW = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  erm_pkg::sample_t                   q_data,
	output logic                               q_pop,
	input  wire logic [erm_pkg::DIST_W-1:0]    obstacle_threshold_q8,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [erm_pkg::DIST_W-1:0]         filtered_distance_q8,
	output logic                               reading_valid,
	output logic                               obstacle,
	output logic [erm_pkg::SAMPLES_W-1:0]      samples_held
);
	import erm_pkg::*;

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANK,
		ST_MED,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [DIST_W-1:0]  win_q [WINDOW];
	logic [IDX_W-1:0]   slot_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [DIST_W-1:0]  lo_q;
	logic [DIST_W-1:0]  hi_q;
	logic [DIST_W-1:0]  med_q;
	logic               item_valid_q;
	logic               out_valid_q;

	logic [DIST_W-1:0]  cand;
	logic [CNT_W-1:0]   rank;
	logic [CNT_W-1:0]   mid;
	logic [DIST_W:0]    pair_sum;
	logic               out_load;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign empty    = !out_valid_q;
	assign cand     = win_q[idx_q];
	assign mid      = count_q >> 1;
	assign pair_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || pop);

	// Sorted position of the candidate; equal values are ordered by slot so ranks are unique.
	always_comb begin
		rank = '0;
		for (int j = 0; j < WINDOW; j++) begin
			if ((CNT_W'(j) < count_q) && ((win_q[j] < cand)
				|| ((win_q[j] == cand) && (CNT_W'(j) < CNT_W'(idx_q))))) begin
				rank = rank + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						item_valid_q <= q_data.valid;
						idx_q        <= '0;
						if (q_data.valid) begin
							win_q[slot_q] <= q_data.distance;
							slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + IDX_W'(1);
							if (count_q != CNT_W'(WINDOW)) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						state_q <= ST_RANK;
					end
				end
				ST_RANK: begin
					if (count_q == '0) begin
						state_q <= ST_MED;
					end else begin
						if (rank == mid - CNT_W'(1)) begin
							lo_q <= cand;
						end
						if (rank == mid) begin
							hi_q <= cand;
						end
						if (CNT_W'(idx_q) == count_q - CNT_W'(1)) begin
							state_q <= ST_MED;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_MED: begin
					if (count_q == '0) begin
						med_q <= '0;
					end else if (count_q[0]) begin
						med_q <= hi_q;
					end else begin
						med_q <= pair_sum[DIST_W:1];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						filtered_distance_q8 <= med_q;
						reading_valid        <= item_valid_q;
						obstacle             <= (med_q != '0) && (med_q < obstacle_threshold_q8);
						samples_held         <= SAMPLES_W'(count_q);
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/echo_ranging_median_filter.sv
// Usage notes:
// Echo requests enter on push/full with echo_rose and pulse_us; one result is
// produced for every request and is read on empty/pop, oldest first.
// Register writes (wr_en, wr_index, wr_data) take effect at the next clock edge
// and are meant to be made while no request is in flight.
// The front end converts the pulse width to Q8 centimetres through its s1 and s2
// registers and checks the timeout and the distance limits. A two-entry queue then
// feeds the back end, which updates the sample ring and finds the median by ranking
// each held sample in turn, one sample per cycle. The back end works on one request
// at a time, stepping through its idle, rank, median and output states, while the
// front end and the queue go on accepting requests as long as they have room.
// Reset empties the sample ring and loads the default register values.
// If the receiver does not pop, the result register holds its value, the back
// end waits with the next result, and full rises once the queue and the front
// stages have filled.
`default_nettype none

module echo_ranging_median_filter #(
	parameter int WINDOW = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic                           echo_rose,
	input  wire logic [erm_pkg::PULSE_W-1:0]    pulse_us,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [erm_pkg::DIST_W-1:0]          filtered_distance_q8,
	output logic                                reading_valid,
	output logic                                obstacle,
	output logic [erm_pkg::SAMPLES_W-1:0]       samples_held,
	input  wire logic                           wr_en,
	input  wire logic [erm_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [erm_pkg::DIST_W-1:0]     wr_data
);
	import erm_pkg::*;

	logic [PULSE_W-1:0] timeout_q;
	logic [DIST_W-1:0]  min_dist_q;
	logic [DIST_W-1:0]  max_dist_q;
	logic [DIST_W-1:0]  threshold_q;

	logic    fq_push;
	logic    fq_full;
	sample_t fq_push_data;
	logic    fq_pop;
	logic    fq_empty;
	sample_t fq_pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			min_dist_q  <= MIN_DIST_RESET;
			max_dist_q  <= MAX_DIST_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_TIMEOUT:   timeout_q   <= wr_data[PULSE_W-1:0];
				REG_MIN_DIST:  min_dist_q  <= wr_data;
				REG_MAX_DIST:  max_dist_q  <= wr_data;
				REG_THRESHOLD: threshold_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	erm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.echo_rose       (echo_rose),
		.pulse_us        (pulse_us),
		.timeout_us      (timeout_q),
		.min_distance_q8 (min_dist_q),
		.max_distance_q8 (max_dist_q),
		.q_push          (fq_push),
		.q_data          (fq_push_data),
		.q_full          (fq_full)
	);

	erm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_data (fq_push_data),
		.full      (fq_full),
		.pop       (fq_pop),
		.pop_data  (fq_pop_data),
		.empty     (fq_empty)
	);

	erm_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.q_empty               (fq_empty),
		.q_data                (fq_pop_data),
		.q_pop                 (fq_pop),
		.obstacle_threshold_q8 (threshold_q),
		.empty                 (empty),
		.pop                   (pop),
		.filtered_distance_q8  (filtered_distance_q8),
		.reading_valid         (reading_valid),
		.obstacle              (obstacle),
		.samples_held          (samples_held)
	);

endmodule

`default_nettype wire
